// ===== rtl/ktaf_pkg.sv =====
// Package for the Kalman tilt filter: widths, payload structs, register indexes.
// No dependencies.
package ktaf_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRACTION_BITS = 20;
  localparam int CFG_BITS = 25;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_Q_ANGLE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_Q_RATE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_R_MEAS  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DT      = 2'd3;

  localparam logic [20:0] RST_Q_ANGLE = 21'd1049;
  localparam logic [20:0] RST_Q_RATE  = 21'd3146;
  localparam logic [24:0] RST_R_MEAS  = 25'd524288;
  localparam logic [20:0] RST_DT      = 21'd5243;

  localparam logic signed [WORD_BITS-1:0] ONE_FX =
    WORD_BITS'(64'sd1 <<< FRACTION_BITS);
  localparam logic signed [WORD_BITS-1:0] MAX_FX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] MIN_FX = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [31:0] accel_angle;
    logic signed [31:0] gyro_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] bias_estimate;
  } out_item_t;

  // Saturate a one-bit-grown signed sum to WORD_BITS.
  function automatic logic signed [WORD_BITS-1:0] sat1(
      input logic signed [WORD_BITS:0] v);
    logic signed [WORD_BITS-1:0] r;
    r = v[WORD_BITS-1:0];
    if (v[WORD_BITS] != v[WORD_BITS-1]) r = v[WORD_BITS] ? MIN_FX : MAX_FX;
    return r;
  endfunction

endpackage

// ===== rtl/ktaf_muldiv.sv =====
// Shared fixed-point multiply (registered result) and restoring divide (one bit a cycle).
// Depends on ktaf_pkg.
module ktaf_muldiv (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic                                     div_i,
  input  logic signed [ktaf_pkg::WORD_BITS-1:0]    a_i,
  input  logic signed [ktaf_pkg::WORD_BITS-1:0]    b_i,
  output logic                                     done_o,
  output logic signed [ktaf_pkg::WORD_BITS-1:0]    res_o
);
  localparam int W = ktaf_pkg::WORD_BITS;
  localparam int F = ktaf_pkg::FRACTION_BITS;
  localparam int STEPS = W + F;
  localparam int CW = $clog2(STEPS + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          neg_q, neg_d, over_q, over_d;
  logic [W-1:0]  md_q, md_d;
  logic [STEPS-1:0] sh_q, sh_d;   // numerator shifted left by F
  logic [W:0]    rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic          done_q, done_d;
  logic signed [W-1:0] res_q, res_d;

  logic [W-1:0]   ma, mb;
  logic [2*W-1:0] prod;
  logic [W:0]     rsh;
  logic           ge;

  function automatic logic signed [W-1:0] sres(
      input logic [W-1:0] m, input logic neg, input logic over);
    logic signed [W-1:0] r;
    if (neg) begin
      if (over || m > {1'b1, {(W-1){1'b0}}}) r = ktaf_pkg::MIN_FX;
      else r = -$signed(m);
    end else begin
      if (over || m[W-1]) r = ktaf_pkg::MAX_FX;
      else r = $signed(m);
    end
    return r;
  endfunction

  always_comb begin
    ma = a_i[W-1] ? W'(-a_i) : W'(a_i);
    mb = b_i[W-1] ? W'(-b_i) : W'(b_i);
    prod = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
    rsh = {rem_q[W-1:0], sh_q[STEPS-1]};
    ge = rsh >= {1'b0, md_q};
  end

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; neg_d = neg_q; over_d = over_q;
    md_d = md_q; sh_d = sh_q; rem_d = rem_q; quo_d = quo_q;
    done_d = 1'b0; res_d = res_q;
    if (start_i && !div_i) begin
      done_d = 1'b1;
      res_d = sres(prod[W+F-1:F], a_i[W-1] ^ b_i[W-1], |prod[2*W-1:W+F]);
    end else if (start_i) begin
      if (mb == '0) begin
        done_d = 1'b1;
        res_d = '0;
      end else begin
        busy_d = 1'b1;
        cnt_d = CW'(STEPS);
        neg_d = a_i[W-1] ^ b_i[W-1];
        over_d = 1'b0;
        md_d = mb;
        sh_d = {ma, {F{1'b0}}};
        rem_d = '0;
        quo_d = '0;
      end
    end else if (busy_q) begin
      sh_d = {sh_q[STEPS-2:0], 1'b0};
      quo_d = {quo_q[W-2:0], ge};
      rem_d = ge ? rsh - {1'b0, md_q} : rsh;
      // quotient bits above the word mean overflow
      if (ge && cnt_q > CW'(W)) over_d = 1'b1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d = sres({quo_q[W-2:0], ge}, neg_q, over_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d; over_q <= over_d; md_q <= md_d; sh_q <= sh_d;
    rem_q <= rem_d; quo_q <= quo_d; res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o = res_q;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("start while divider busy");
  a_done_after_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == CW'(1)) |=> done_q) else $error("divide did not finish");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0)) else $error("divider count ran out");
`endif
endmodule

// ===== rtl/kalman_tilt_angle_fusion.sv =====
// Top level of the two-state Kalman tilt filter: sequencer, state, config.
// Depends on ktaf_pkg and ktaf_muldiv.
//
// Usage: one input transfer (accel_angle, gyro_rate) yields one output
// transfer (angle_estimate, bias_estimate). Configuration writes (cfg_we_i,
// cfg_idx_i, cfg_data_i) take effect at once; the user must make them only
// while idle, as the block itself does not enforce this. An item runs as a
// fixed list of 12 operations on one shared unit: 10 multiplies, each with a
// registered result, and two gain divides of 52 quotient bits at one bit a
// cycle. in_ready_o stays low until the result is loaded, so a new item is
// not taken before the last one is through. The result sits in an output
// register; the next input is accepted while it waits, and the sequencer
// only stalls at the final step if the previous result has not been taken
// yet. Reset puts angle and bias to zero, the covariance to identity and
// the registers to their default values; no clearing pass is needed.
module kalman_tilt_angle_fusion (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ktaf_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ktaf_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [ktaf_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [ktaf_pkg::CFG_BITS-1:0] cfg_data_i
);
  localparam int W = ktaf_pkg::WORD_BITS;

  // step codes
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_PA   = 5'd1;  // m = mul(sat(gyr-bias), dt)
  localparam logic [4:0] S_PB   = 5'd2;  // angle += m ; m = mul(sat(-ab-ba), dt)
  localparam logic [4:0] S_PC   = 5'd3;  // aa = sat(aa+m+qa); m = mul(bb,dt)
  localparam logic [4:0] S_PD   = 5'd4;  // ab,ba -= m ; m = mul(qg,dt)
  localparam logic [4:0] S_PE   = 5'd5;  // bb += m ; err, e; div(aa,e)
  localparam logic [4:0] S_K0   = 5'd6;  // k0 = q ; div(ba,e)
  localparam logic [4:0] S_K1   = 5'd7;  // k1 = q ; mul(k0,aa)
  localparam logic [4:0] S_C1   = 5'd8;  // naa ; mul(k0,ab)
  localparam logic [4:0] S_C2   = 5'd9;  // nab ; mul(k1,aa)
  localparam logic [4:0] S_C3   = 5'd10; // nba ; mul(k1,ab)
  localparam logic [4:0] S_C4   = 5'd11; // nbb ; mul(k0,err)
  localparam logic [4:0] S_C5   = 5'd12; // angle ; mul(k1,err)
  localparam logic [4:0] S_C6   = 5'd13; // bias ; emit

  logic [20:0] qa_q, qg_q, dt_q;
  logic [24:0] rn_q;
  logic [4:0]  st_q, st_d;
  logic signed [W-1:0] ang_q, bias_q, aa_q, ab_q, ba_q, bb_q;
  logic signed [W-1:0] acc_q, err_q, e_q, k0_q, k1_q, t0_q, t1_q;
  logic signed [W-1:0] ang_d, bias_d, aa_d, ab_d, ba_d, bb_d;
  logic signed [W-1:0] err_d, e_d, k0_d, k1_d, t0_d, t1_d;
  logic        ov_q, ov_d;
  ktaf_pkg::out_item_t od_q, od_d;

  logic        u_start, u_div, u_done;
  logic signed [W-1:0] u_a, u_b, u_r;
  logic signed [W-1:0] dt_s, qa_s, qg_s, rn_s;

  assign dt_s = W'($signed({1'b0, dt_q}));
  assign qa_s = W'($signed({1'b0, qa_q}));
  assign qg_s = W'($signed({1'b0, qg_q}));
  assign rn_s = W'($signed({1'b0, rn_q}));

  ktaf_muldiv u_md (
    .clk_i, .rst_ni, .start_i(u_start), .div_i(u_div),
    .a_i(u_a), .b_i(u_b), .done_o(u_done), .res_o(u_r)
  );

  function automatic logic signed [W-1:0] add(
      input logic signed [W-1:0] x, input logic signed [W-1:0] y);
    return ktaf_pkg::sat1({x[W-1], x} + {y[W-1], y});
  endfunction
  function automatic logic signed [W-1:0] sub(
      input logic signed [W-1:0] x, input logic signed [W-1:0] y);
    return ktaf_pkg::sat1({x[W-1], x} - {y[W-1], y});
  endfunction
  // Saturate a two-bit-grown signed value to W bits.
  function automatic logic signed [W-1:0] sat2(input logic signed [W+1:0] v);
    logic signed [W-1:0] r;
    r = v[W-1:0];
    if (v[W+1:W-1] != {3{v[W-1]}}) r = v[W+1] ? ktaf_pkg::MIN_FX : ktaf_pkg::MAX_FX;
    return r;
  endfunction
  // sat(-x - y) without an intermediate wrap of -x
  function automatic logic signed [W-1:0] neg_sum(
      input logic signed [W-1:0] x, input logic signed [W-1:0] y);
    logic signed [W+1:0] s;
    s = -({{2{x[W-1]}}, x} + {{2{y[W-1]}}, y});
    return sat2(s);
  endfunction

  assign in_ready_o = (st_q == S_IDLE);

  always_comb begin
    st_d = st_q;
    ang_d = ang_q; bias_d = bias_q; aa_d = aa_q; ab_d = ab_q; ba_d = ba_q; bb_d = bb_q;
    err_d = err_q; e_d = e_q; k0_d = k0_q; k1_d = k1_q; t0_d = t0_q; t1_d = t1_q;
    ov_d = ov_q; od_d = od_q;
    u_start = 1'b0; u_div = 1'b0; u_a = '0; u_b = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          st_d = S_PA; u_start = 1'b1;
          u_a = sub(in_data_i.gyro_rate, bias_q); u_b = dt_s;
        end
      end
      S_PA: if (u_done) begin
        ang_d = add(ang_q, u_r);
        st_d = S_PB; u_start = 1'b1;
        u_a = neg_sum(ab_q, ba_q); u_b = dt_s;
      end
      S_PB: if (u_done) begin
        aa_d = sat2({{2{aa_q[W-1]}}, aa_q} + {{2{u_r[W-1]}}, u_r}
                    + {{2{qa_s[W-1]}}, qa_s});
        st_d = S_PC; u_start = 1'b1; u_a = bb_q; u_b = dt_s;
      end
      S_PC: if (u_done) begin
        ab_d = sub(ab_q, u_r); ba_d = sub(ba_q, u_r);
        st_d = S_PD; u_start = 1'b1; u_a = qg_s; u_b = dt_s;
      end
      S_PD: if (u_done) begin
        bb_d = add(bb_q, u_r);
        err_d = sub(acc_q, ang_q);
        e_d = add(rn_s, aa_q);
        st_d = S_PE; u_start = 1'b1; u_div = 1'b1;
        u_a = aa_q; u_b = add(rn_s, aa_q);
      end
      S_PE: if (u_done) begin
        k0_d = u_r;
        st_d = S_K0; u_start = 1'b1; u_div = 1'b1; u_a = ba_q; u_b = e_q;
      end
      S_K0: if (u_done) begin
        k1_d = u_r; t0_d = aa_q; t1_d = ab_q;
        st_d = S_K1; u_start = 1'b1; u_a = k0_q; u_b = aa_q;
      end
      S_K1: if (u_done) begin
        aa_d = sub(aa_q, u_r);
        st_d = S_C1; u_start = 1'b1; u_a = k0_q; u_b = t1_q;
      end
      S_C1: if (u_done) begin
        ab_d = sub(ab_q, u_r);
        st_d = S_C2; u_start = 1'b1; u_a = k1_q; u_b = t0_q;
      end
      S_C2: if (u_done) begin
        ba_d = sub(ba_q, u_r);
        st_d = S_C3; u_start = 1'b1; u_a = k1_q; u_b = t1_q;
      end
      S_C3: if (u_done) begin
        bb_d = sub(bb_q, u_r);
        st_d = S_C4; u_start = 1'b1; u_a = k0_q; u_b = err_q;
      end
      S_C4: if (u_done) begin
        ang_d = add(ang_q, u_r);
        st_d = S_C5; u_start = 1'b1; u_a = k1_q; u_b = err_q;
      end
      S_C5: if (u_done) begin
        bias_d = add(bias_q, u_r);
        st_d = S_C6;
      end
      S_C6: begin
        if (!ov_d) begin
          ov_d = 1'b1;
          od_d.angle_estimate = ang_q;
          od_d.bias_estimate = bias_q;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ov_q <= 1'b0;
      ang_q <= '0; bias_q <= '0;
      aa_q <= ktaf_pkg::ONE_FX; ab_q <= '0; ba_q <= '0; bb_q <= ktaf_pkg::ONE_FX;
      qa_q <= ktaf_pkg::RST_Q_ANGLE; qg_q <= ktaf_pkg::RST_Q_RATE;
      rn_q <= ktaf_pkg::RST_R_MEAS; dt_q <= ktaf_pkg::RST_DT;
    end else begin
      st_q <= st_d; ov_q <= ov_d;
      ang_q <= ang_d; bias_q <= bias_d;
      aa_q <= aa_d; ab_q <= ab_d; ba_q <= ba_d; bb_q <= bb_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ktaf_pkg::REG_Q_ANGLE: qa_q <= cfg_data_i[20:0];
          ktaf_pkg::REG_Q_RATE:  qg_q <= cfg_data_i[20:0];
          ktaf_pkg::REG_R_MEAS:  rn_q <= cfg_data_i;
          ktaf_pkg::REG_DT:      dt_q <= cfg_data_i[20:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && in_valid_i) acc_q <= in_data_i.accel_angle;
    err_q <= err_d; e_q <= e_d; k0_q <= k0_d; k1_q <= k1_d;
    t0_q <= t0_d; t1_q <= t1_d; od_q <= od_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o = od_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("accepted twice");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped");
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_start |-> (st_q == S_IDLE || u_done)) else $error("unit restarted early");
`endif
endmodule
